// File: sv/slri_pkg.sv
// ----------------------------------------------------------------------------
// slri_pkg
// Shared types and codes for the sorted list insert/remove unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slri_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RANK      = 3'd4
    } t_status;

    // per-cycle command to every cell of the row
    typedef struct packed {
        logic do_ins;
        logic do_rem;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: sv/slri_cell.sv
// ----------------------------------------------------------------------------
// slri_cell
// One slot of the ordered row: holds a key, compares it with the command key;
// insert takes the left neighbour's or command key, remove the right one's.
// ----------------------------------------------------------------------------
`default_nettype none

module slri_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  wire                      i_clk,
    input  slri_pkg::t_cell_ctrl     i_ctrl,
    input  wire  [KEY_WIDTH-1:0]     i_key,
    input  wire                      i_valid,
    input  wire  [KEY_WIDTH-1:0]     i_left_entry,
    input  wire                      i_left_open,
    input  wire  [KEY_WIDTH-1:0]     i_right_entry,
    input  wire                      i_sel_rd,
    input  wire                      i_sel_last,
    output logic [KEY_WIDTH-1:0]     o_entry,
    output logic                     o_open,
    output logic                     o_ge,
    output logic                     o_eq,
    output logic [KEY_WIDTH-1:0]     o_tap_rd,
    output logic [KEY_WIDTH-1:0]     o_tap_last
);

    logic [KEY_WIDTH-1:0] r_entry;
    logic [KEY_WIDTH-1:0] n_entry;

    // open: insert position is here or to the left
    assign o_open = !i_valid || ($signed(r_entry) > $signed(i_key));
    assign o_ge   = i_valid && ($signed(r_entry) >= $signed(i_key));
    assign o_eq   = i_valid && (r_entry == i_key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.do_ins) begin
            if (i_left_open) begin
                n_entry = i_left_entry;
            end else if (o_open) begin
                n_entry = i_key;
            end
        end else if (i_ctrl.do_rem && o_ge) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry    = r_entry;
    assign o_tap_rd   = i_sel_rd   ? r_entry : '0;
    assign o_tap_last = i_sel_last ? r_entry : '0;

endmodule

`default_nettype wire

// File: sv/sorted_list_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit
// Bounded ascending store of signed keys held in a row of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_cmd, i_value and i_rank with start high; the item is taken at
//   the edge where start is high and busy is low.
//   Insert puts the key after its equals, remove drops the first equal
//   entry, read returns the entry at i_rank counted from the smallest.
//   Every item gives one result, shown for one cycle with o_done high:
//   status, read value, entry count, smallest, largest and empty flag.
//   Timing: the row updates at the accepting edge; the result is
//   registered at the next edge, as o_done rises. busy is high for one
//   cycle after each accept, and no new item is taken while busy is
//   high. Reset clears the count and the busy and done flags only; key
//   slots hold unknown data until written and are never shown before
//   that. The receiver cannot stall: each result is taken in its strobe
//   cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove_unit #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_cmd,
    input  wire  [31:0] i_value,
    input  wire  [3:0]  i_rank,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_value,
    output logic [4:0]  o_entry_count,
    output logic [31:0] o_smallest,
    output logic [31:0] o_largest,
    output logic        o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > 5) ? CW : 5;

    logic                   r_pend;
    logic                   r_done;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    slri_pkg::t_status      r_status;
    slri_pkg::t_status      n_status;
    logic                   r_rd_ok;
    logic [3:0]             r_rank;

    logic [2:0]             r_o_status;
    logic [31:0]            r_o_read_value;
    logic [4:0]             r_o_count;
    logic [31:0]            r_o_smallest;
    logic [31:0]            r_o_largest;
    logic                   r_o_empty;

    logic                   accept;
    slri_pkg::t_cmd         cmd;
    logic [KEY_WIDTH-1:0]   key;
    logic                   full;
    logic                   found;
    logic                   rank_ok;
    slri_pkg::t_cell_ctrl   ctrl;
    logic [EW-1:0]          cnt_ext;

    logic [KEY_WIDTH-1:0]   entry    [DEPTH];
    logic [KEY_WIDTH-1:0]   tap_rd   [DEPTH];
    logic [KEY_WIDTH-1:0]   tap_last [DEPTH];
    logic [DEPTH-1:0]       valid;
    logic [DEPTH-1:0]       open_v;
    logic [DEPTH-1:0]       ge_v;
    logic [DEPTH-1:0]       eq_v;
    logic [DEPTH-1:0]       sel_rd;
    logic [DEPTH-1:0]       sel_last;

    logic [KEY_WIDTH-1:0]   rd_key;
    logic [KEY_WIDTH-1:0]   last_key;
    logic [31:0]            rd_out;
    logic [31:0]            last_out;
    logic [31:0]            first_out;

    assign accept = start && !r_pend;
    assign busy   = r_pend;
    assign cmd    = slri_pkg::t_cmd'(i_cmd);
    assign full   = (32'(r_count) >= 32'(DEPTH));
    assign found  = |eq_v;
    assign cnt_ext = EW'(r_count);
    assign rank_ok = (EW'(i_rank) < cnt_ext);

    // key is the low KEY_WIDTH bits of the 32-bit value, zero-extended if wider
    generate
        if (KEY_WIDTH <= 32) begin : g_key_narrow
            assign key       = i_value[KEY_WIDTH-1:0];
            assign rd_out    = 32'($signed(rd_key));
            assign last_out  = 32'($signed(last_key));
            assign first_out = 32'($signed(entry[0]));
        end else begin : g_key_wide
            assign key       = {{(KEY_WIDTH-32){1'b0}}, i_value};
            assign rd_out    = rd_key[31:0];
            assign last_out  = last_key[31:0];
            assign first_out = entry[0][31:0];
        end
    endgenerate

    assign ctrl.do_ins = accept && (cmd == slri_pkg::CMD_INSERT) && !full;
    assign ctrl.do_rem = accept && (cmd == slri_pkg::CMD_REMOVE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_row
            assign valid[gi]  = (32'(r_count) > 32'(gi));
            assign sel_rd[gi] = (32'(r_rank) == 32'(gi));
            if (gi == DEPTH - 1) begin : g_tail
                assign sel_last[gi] = valid[gi];
            end else begin : g_mid
                assign sel_last[gi] = valid[gi] && !valid[gi+1];
            end

            slri_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (ctrl),
                .i_key         (key),
                .i_valid       (valid[gi]),
                .i_left_entry  ((gi == 0) ? key : entry[(gi == 0) ? 0 : gi-1]),
                .i_left_open   ((gi == 0) ? 1'b0 : open_v[(gi == 0) ? 0 : gi-1]),
                .i_right_entry (entry[(gi == DEPTH-1) ? gi : gi+1]),
                .i_sel_rd      (sel_rd[gi]),
                .i_sel_last    (sel_last[gi]),
                .o_entry       (entry[gi]),
                .o_open        (open_v[gi]),
                .o_ge          (ge_v[gi]),
                .o_eq          (eq_v[gi]),
                .o_tap_rd      (tap_rd[gi]),
                .o_tap_last    (tap_last[gi])
            );
        end
    endgenerate

    always_comb begin
        rd_key   = '0;
        last_key = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_key   = rd_key | tap_rd[k];
            last_key = last_key | tap_last[k];
        end
    end

    always_comb begin
        n_status = slri_pkg::ST_OK;
        n_count  = r_count;
        unique case (cmd)
            slri_pkg::CMD_INSERT: begin
                if (full) begin
                    n_status = slri_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            slri_pkg::CMD_REMOVE: begin
                if (r_count == '0) begin
                    n_status = slri_pkg::ST_EMPTY;
                end else if (!found) begin
                    n_status = slri_pkg::ST_NOT_FOUND;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            slri_pkg::CMD_READ: begin
                if (r_count == '0) begin
                    n_status = slri_pkg::ST_EMPTY;
                end else if (!rank_ok) begin
                    n_status = slri_pkg::ST_RANK;
                end
            end
            slri_pkg::CMD_NOP: begin
                n_status = slri_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_pend <= accept;
            r_done <= r_pend;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rank   <= i_rank;
            r_rd_ok  <= (cmd == slri_pkg::CMD_READ) && (r_count != '0) && rank_ok;
        end
        if (r_pend) begin
            r_o_status     <= r_status;
            r_o_read_value <= r_rd_ok ? rd_out : 32'd0;
            r_o_count      <= cnt_ext[4:0];
            r_o_empty      <= (r_count == '0);
            r_o_smallest   <= (r_count == '0) ? 32'd0 : first_out;
            r_o_largest    <= (r_count == '0) ? 32'd0 : last_out;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_read_value;
    assign o_entry_count = r_o_count;
    assign o_smallest    = r_o_smallest;
    assign o_largest     = r_o_largest;
    assign o_is_empty    = r_o_empty;

    // checks
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> (r_done && !r_pend))
        else $error("result strobe missing after item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("entry count beyond depth");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (cmd == slri_pkg::CMD_INSERT) && full) |=> $stable(r_count))
        else $error("insert into full store changed the count");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (o_is_empty == (o_entry_count == 5'd0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

// File: tb/sorted_list_insert_remove_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit_tb
// Self-checking bench for the sorted list insert/remove unit.
// ----------------------------------------------------------------------------
// A shadow ordered store predicts every result. Directed items hit the empty
// store, extreme keys, equal keys, removal of the head and the tail, and
// reads past the count. Random phases then fill the store to full, drain it
// to empty and mix commands, with bursty and gap-free sending.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_list_insert_remove_unit_tb;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 400;

    typedef struct packed {
        slri_pkg::t_status status;
        logic [31:0]       read_value;
        logic [4:0]        count;
        logic [31:0]       smallest;
        logic [31:0]       largest;
        logic              is_empty;
    } t_outcome;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic [1:0]  i_cmd   = '0;
    logic [31:0] i_value = '0;
    logic [3:0]  i_rank  = '0;
    logic        busy;
    logic        o_done;
    logic [2:0]  o_status;
    logic [31:0] o_read_value;
    logic [4:0]  o_entry_count;
    logic [31:0] o_smallest;
    logic [31:0] o_largest;
    logic        o_is_empty;

    logic signed [31:0] shadow_keys [DEPTH];
    int                 shadow_count = 0;
    t_outcome           pending_results [$];

    int  errors         = 0;
    int  items_sent     = 0;
    int  full_rejects   = 0;
    int  absent_removes = 0;
    int  rank_overruns  = 0;
    int  empty_hits     = 0;
    int  stall_cycles   = 0;
    int  burst_left     = 0;
    bit  bursty         = 1'b1;

    sorted_list_insert_remove_unit #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_rank        (i_rank),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_smallest    (o_smallest),
        .o_largest     (o_largest),
        .o_is_empty    (o_is_empty)
    );

    always #1 i_clk = ~i_clk;

    // shadow store update and expected result for one item
    function automatic t_outcome apply_to_shadow(slri_pkg::t_cmd cmd,
                                                 logic signed [31:0] key,
                                                 logic [3:0] rank);
        t_outcome res;
        int       pos;
        int       i;
        res        = '0;
        res.status = slri_pkg::ST_OK;
        case (cmd)
            slri_pkg::CMD_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = slri_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
                    for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                end
            end
            slri_pkg::CMD_REMOVE: begin
                if (shadow_count == 0) begin
                    res.status = slri_pkg::ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] !== key) pos++;
                    if (pos >= shadow_count) begin
                        res.status = slri_pkg::ST_NOT_FOUND;
                    end else begin
                        for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
                        shadow_count--;
                    end
                end
            end
            slri_pkg::CMD_READ: begin
                if (shadow_count == 0) res.status = slri_pkg::ST_EMPTY;
                else if (rank >= shadow_count) res.status = slri_pkg::ST_RANK;
                else res.read_value = shadow_keys[rank];
            end
            default: ;
        endcase
        res.count = shadow_count[4:0];
        if (shadow_count == 0) begin
            res.is_empty = 1'b1;
        end else begin
            res.smallest = shadow_keys[0];
            res.largest  = shadow_keys[shadow_count-1];
        end
        return res;
    endfunction

    task automatic send_item(input slri_pkg::t_cmd cmd, input logic signed [31:0] key,
                             input logic [3:0] rank);
        int gap;
        if (bursty && burst_left == 0) begin
            gap   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= key;
        i_rank  <= rank;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        pending_results.push_back(apply_to_shadow(cmd, key, rank));
        items_sent++;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $signed($urandom_range(0, 16)) - 8;
            3: return (shadow_count > 0) ? shadow_keys[$urandom_range(0, shadow_count-1)]
                                         : $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_store();
        send_item(slri_pkg::CMD_READ, 32'sd0, 4'd0);
        send_item(slri_pkg::CMD_REMOVE, 32'sd5, 4'd3);
        send_item(slri_pkg::CMD_NOP, 32'sh1234_5678, 4'd15);
    endtask

    task automatic test_extremes_and_equal_keys();
        send_item(slri_pkg::CMD_INSERT, 32'sh8000_0000, 4'd0);
        send_item(slri_pkg::CMD_INSERT, 32'sh7fff_ffff, 4'd0);
        send_item(slri_pkg::CMD_INSERT, 32'sd0, 4'd0);
        send_item(slri_pkg::CMD_INSERT, -32'sd1, 4'd0);
        send_item(slri_pkg::CMD_INSERT, 32'sd7, 4'd0);
        send_item(slri_pkg::CMD_INSERT, 32'sd7, 4'd0);
        send_item(slri_pkg::CMD_INSERT, 32'sh8000_0000, 4'd0);
        send_item(slri_pkg::CMD_READ, 32'sd0, 4'd0);
        send_item(slri_pkg::CMD_READ, 32'sd0, 4'd6);
        send_item(slri_pkg::CMD_READ, 32'sd0, 4'd7);
        send_item(slri_pkg::CMD_READ, 32'sd0, 4'd15);
        send_item(slri_pkg::CMD_REMOVE, 32'sd3, 4'd0);
        send_item(slri_pkg::CMD_REMOVE, 32'sd7, 4'd0);
        send_item(slri_pkg::CMD_REMOVE, 32'sh7fff_ffff, 4'd0);
        send_item(slri_pkg::CMD_REMOVE, 32'sh8000_0000, 4'd0);
        send_item(slri_pkg::CMD_NOP, 32'sd0, 4'd0);
    endtask

    task automatic run_random_phase(input int n_items, input int insert_pct,
                                    input int remove_pct, input bit idle_on);
        int                 n;
        int                 roll;
        slri_pkg::t_cmd     cmd;
        logic signed [31:0] key;
        logic [3:0]         rank;
        bursty     = idle_on;
        burst_left = 0;
        for (n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) cmd = slri_pkg::CMD_INSERT;
            else if (roll < insert_pct + remove_pct) cmd = slri_pkg::CMD_REMOVE;
            else if (roll < 97) cmd = slri_pkg::CMD_READ;
            else cmd = slri_pkg::CMD_NOP;
            if (cmd == slri_pkg::CMD_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 7)
                key = shadow_keys[$urandom_range(0, shadow_count-1)];
            else
                key = pick_key();
            if ($urandom_range(0, 4) != 0 && shadow_count > 0)
                rank = 4'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
            else
                rank = 4'($urandom_range(0, 15));
            send_item(cmd, key, rank);
        end
    endtask

    task automatic test_fill_to_full();
        run_random_phase(500, 65, 15, 1'b1);
    endtask

    task automatic test_drain_to_empty();
        run_random_phase(450, 15, 65, 1'b1);
    endtask

    task automatic test_mixed_back_to_back();
        run_random_phase(500, 35, 35, 1'b0);
    endtask

    task automatic test_mixed_bursty();
        run_random_phase(500, 40, 30, 1'b1);
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    always @(negedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.status), 32'(o_status));
                compare_field("read_value", want.read_value, o_read_value);
                compare_field("entry_count", 32'(want.count), 32'(o_entry_count));
                compare_field("smallest", want.smallest, o_smallest);
                compare_field("largest", want.largest, o_largest);
                compare_field("is_empty", 32'(want.is_empty), 32'(o_is_empty));
                case (want.status)
                    slri_pkg::ST_FULL:      full_rejects++;
                    slri_pkg::ST_NOT_FOUND: absent_removes++;
                    slri_pkg::ST_RANK:      rank_overruns++;
                    slri_pkg::ST_EMPTY:     empty_hits++;
                    default: ;
                endcase
            end
        end
    end

    always @(negedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[sorted_list_insert_remove_unit] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        test_extremes_and_equal_keys();
        test_fill_to_full();
        test_drain_to_empty();
        test_mixed_back_to_back();
        test_mixed_bursty();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("Ran %0d items: %0d inserts refused on a full store, %0d removes of absent keys,",
                 items_sent, full_rejects, absent_removes);
        $display("%0d reads past the count, %0d removes or reads on an empty store.",
                 rank_overruns, empty_hits);
        if (errors == 0) begin
            $display("[sorted_list_insert_remove_unit] OK");
        end else begin
            $display("[sorted_list_insert_remove_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/slri_pkg.sv
sv/slri_cell.sv
sv/sorted_list_insert_remove_unit.sv
tb/sorted_list_insert_remove_unit_tb.sv
